// ===== design/mmsh_pkg.sv =====
// Package: shared constants, codes and types for the min/max scaled histogram.
`timescale 1ns / 1ps
package mmsh_pkg;
    localparam int BINS_DEFAULT       = 100;
    localparam int COUNT_BITS_DEFAULT = 24;
    localparam int SAMPLE_W           = 16;
    localparam int INDEX_W            = 7;
    localparam int OUT_COUNT_W        = 24;
    localparam int SPAN_W             = 17;
    localparam logic signed [SAMPLE_W-1:0] FIXED_NODATA = -16'sd28768;

    typedef enum logic [1:0] {
        F_RANGE = 2'd0,
        F_BIN   = 2'd1,
        F_READ  = 2'd2,
        F_CLEAR = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         bin_index;
    } t_in_item;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0]     bin_count;
        logic signed [SAMPLE_W-1:0] range_min;
        logic signed [SAMPLE_W-1:0] range_max;
        logic                       counted;
        logic [INDEX_W-1:0]         sample_bin;
    } t_out_item;
endpackage

// ===== design/mmsh_if.sv =====
// Interface: valid/ready channel carrying one item.
`timescale 1ns / 1ps
interface mmsh_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mmsh_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mmsh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/mmsh_div.sv =====
// Restoring divider: quotient of a numerator by a divisor, one bit a cycle.
`timescale 1ns / 1ps
module mmsh_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   n_trial;
    logic [DEN_W:0]   n_shift;

    assign n_shift = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_q <= {r_q[NUM_W-2:0], !n_trial[DEN_W]};
                r_rem <= n_trial[DEN_W] ? n_shift : n_trial;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule

// ===== design/min_max_scaled_histogram_core.sv =====
// Top level: min/max scaled histogram with bin counts in a RAM.
`timescale 1ns / 1ps
// One item at a time. A range-pass item, and a bin-pass sample that is
// dropped, go from accept straight to the result state. A read passes
// through accept, RAM read, capture and result. A counted bin-pass sample
// starts the restoring divider, which forms a quotient of $clog2(BINS+1)+17
// bits one bit a cycle, then reads, modifies and writes the bin RAM. When
// min equals max no divide is run. Clear sweeps the bin RAM one entry a
// cycle. After reset the same sweep clears the RAM before the first item is
// taken; configuration writes are taken throughout. The result sits in an
// output register; the next item is accepted once it has been taken.
module min_max_scaled_histogram_core #(
    parameter int BINS       = mmsh_pkg::BINS_DEFAULT,
    parameter int COUNT_BITS = mmsh_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic signed [mmsh_pkg::SAMPLE_W-1:0] i_cfg_wdata,
    mmsh_if.sink                              i_in,
    mmsh_if.source                            o_out
);
    localparam int AW    = $clog2(BINS);
    localparam int BW    = $clog2(BINS + 1);
    localparam int NUM_W = BW + mmsh_pkg::SPAN_W;
    localparam logic [COUNT_BITS-1:0] SAT = '1;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_DIV, S_RD, S_WR, S_READ, S_OUT
    } t_state;

    t_state r_state;
    logic signed [mmsh_pkg::SAMPLE_W-1:0] r_nodata, r_lo, r_hi, r_smp;
    logic        r_any;
    logic        r_start;
    logic [AW-1:0] r_addr;
    logic [1:0]  r_func;
    logic [mmsh_pkg::INDEX_W-1:0] r_idx;
    mmsh_pkg::t_out_item r_res;

    logic signed [mmsh_pkg::SAMPLE_W-1:0] n_lo, n_hi;
    logic        n_counted;
    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
    logic        div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [mmsh_pkg::SPAN_W-1:0] span, off;
    logic        valid_s, in_range;
    mmsh_pkg::t_in_item in_d;

    assign in_d = i_in.data;
    // A sample is usable when positive and not one of the two no-data codes.
    assign valid_s = (in_d.sample > 0) && (in_d.sample != mmsh_pkg::FIXED_NODATA)
                     && (in_d.sample != r_nodata);
    assign in_range = r_any && (in_d.sample >= r_lo) && (in_d.sample <= r_hi);
    assign span = mmsh_pkg::SPAN_W'(r_hi) - mmsh_pkg::SPAN_W'(r_lo);
    assign off  = mmsh_pkg::SPAN_W'(r_smp) - mmsh_pkg::SPAN_W'(r_lo);
    assign div_num = NUM_W'(BINS) * NUM_W'(off);

    // Range after this item; the first usable sample sets both ends.
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (in_d.func == mmsh_pkg::F_RANGE && valid_s) begin
            if (!r_any || in_d.sample < r_lo) begin
                n_lo = in_d.sample;
            end
            if (!r_any || in_d.sample > r_hi) begin
                n_hi = in_d.sample;
            end
        end
    end
    assign n_counted = valid_s && ((in_d.func == mmsh_pkg::F_RANGE)
                     || (in_d.func == mmsh_pkg::F_BIN && in_range));

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data  = r_res;

    assign ram_raddr = r_addr;
    assign ram_we    = (r_state == S_SWEEP) || (r_state == S_WR);
    assign ram_waddr = r_addr;
    assign ram_wdata = (r_state == S_WR && ram_rdata != SAT) ? ram_rdata + 1'b1
                     : (r_state == S_WR) ? ram_rdata : '0;
    // Pulse the divider once on entry to the divide state; skip it for a zero span.
    assign div_start = r_start && (span != '0);

    mmsh_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata));

    mmsh_div #(.NUM_W(NUM_W), .DEN_W(mmsh_pkg::SPAN_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(span), .o_done(div_done), .o_quot(div_quot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_addr   <= '0;
            r_nodata <= mmsh_pkg::FIXED_NODATA;
            r_lo <= '0;
            r_hi <= '0;
            r_any <= 1'b0;
            r_func <= '0;
            r_start <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_nodata <= i_cfg_wdata;
            end
            r_start <= (r_state == S_IDLE) && i_in.valid
                       && (in_d.func == mmsh_pkg::F_BIN) && valid_s && in_range;
            case (r_state)
                S_SWEEP: begin
                    if (r_addr == AW'(BINS - 1)) begin
                        r_addr  <= '0;
                        r_state <= (r_func == mmsh_pkg::F_CLEAR) ? S_OUT : S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func <= in_d.func;
                        r_smp  <= in_d.sample;
                        r_idx  <= in_d.bin_index;
                        r_res  <= '{bin_count: '0, range_min: n_lo, range_max: n_hi,
                                   counted: n_counted, sample_bin: '0};
                        case (in_d.func)
                            mmsh_pkg::F_RANGE: begin
                                if (valid_s) begin
                                    r_any <= 1'b1;
                                    r_lo  <= n_lo;
                                    r_hi  <= n_hi;
                                end
                                r_state <= S_OUT;
                            end
                            mmsh_pkg::F_BIN: begin
                                if (valid_s && in_range) begin
                                    r_state <= S_DIV;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            mmsh_pkg::F_READ: begin
                                r_addr  <= AW'(in_d.bin_index);
                                r_state <= S_RD;
                            end
                            default: begin
                                r_addr  <= '0;
                                r_state <= S_SWEEP;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    // Span zero means min equals max: bin 0, no divide.
                    if (span == '0) begin
                        r_addr  <= '0;
                        r_state <= S_RD;
                    end else if (div_done) begin
                        // Sample at the maximum folds into the last bin.
                        r_addr  <= (div_quot >= NUM_W'(BINS)) ? AW'(BINS - 1)
                                                              : AW'(div_quot);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= (r_func == mmsh_pkg::F_BIN) ? S_WR : S_READ;
                end
                S_WR: begin
                    r_res.sample_bin <= mmsh_pkg::INDEX_W'(r_addr);
                    r_state <= S_OUT;
                end
                S_READ: begin
                    if (BW'(r_idx) < BW'(BINS) && 32'(r_idx) < BINS) begin
                        r_res.bin_count <= mmsh_pkg::OUT_COUNT_W'(ram_rdata);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/mmsh_checker.sv =====
// Checker: port-level properties of the histogram core, bound to the top level.
`timescale 1ns / 1ps
module mmsh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input mmsh_pkg::t_out_item out_data
);
    // Never take an item while a result waits.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    // A held result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
    // Range never inverts.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.range_min <= out_data.range_max)
        else $error("min above max");
    // A counted sample, range-pass or placed, carries no read count.
    a_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.counted |-> out_data.bin_count == '0)
        else $error("count on sample item");
endmodule

bind min_max_scaled_histogram_core mmsh_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data));
